[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/ehts_pkg.sv]
// ----------------------------------------------------------------------------
// Hold and tap sequencer package
// Types, codes, reset values and the event helpers of the sequencer.
// ----------------------------------------------------------------------------
package ehts_pkg;

	localparam int MaxEv = 5;
	localparam int CntW  = $clog2(MaxEv + 1);

	localparam logic [31:0] HoldKeyRst    = 32'd0;
	localparam logic [15:0] IdleWindowRst = 16'd750;
	localparam logic [7:0]  ArmDelayRst   = 8'd15;
	localparam logic [7:0]  TapLengthRst  = 8'd25;

	typedef enum logic [1:0] {
		OP_DETENT_PRESS   = 2'd0,
		OP_DETENT_RELEASE = 2'd1,
		OP_OTHER_KEY      = 2'd2,
		OP_TICK           = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_HOLD_KEY    = 2'd0,
		REG_IDLE_WINDOW = 2'd1,
		REG_ARM_DELAY   = 2'd2,
		REG_TAP_LENGTH  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] code;
		logic        down;
	} event_t;

	typedef struct packed {
		logic        session_active;
		logic        hold_pressed;
		logic        tap_pressed;
		logic        tap_deferred;
		logic        tap_self_timed;
		logic        end_pending_tap;
		logic [31:0] tap_key;
		logic [15:0] idle_cnt;
		logic        idle_armed;
		logic [7:0]  arm_cnt;
		logic [7:0]  tap_cnt;
		logic        tap_armed;
	} state_t;

	typedef struct packed {
		state_t                  st;
		logic [CntW-1:0]         cnt;
		event_t [MaxEv-1:0]      ev;
	} ctx_t;

	function automatic ctx_t emit(ctx_t c, logic [31:0] code, logic down);
		ctx_t r;
		r = c;
		if (r.cnt < CntW'(MaxEv)) begin
			r.ev[r.cnt].code = code;
			r.ev[r.cnt].down = down;
			r.cnt = r.cnt + CntW'(1);
		end
		return r;
	endfunction

	function automatic ctx_t release_tap(ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.tap_pressed) begin
			r.st.tap_pressed = 1'b0;
			r.st.tap_self_timed = 1'b0;
			r = emit(r, r.st.tap_key, 1'b0);
		end
		return r;
	endfunction

	function automatic ctx_t release_hold(ctx_t c, logic [31:0] hold_code);
		ctx_t r;
		r = c;
		r.st.session_active = 1'b0;
		r.st.end_pending_tap = 1'b0;
		r.st.tap_deferred = 1'b0;
		if (r.st.hold_pressed) begin
			r.st.hold_pressed = 1'b0;
			r = emit(r, hold_code, 1'b0);
		end
		return r;
	endfunction

	function automatic ctx_t after_tap(ctx_t c, logic [31:0] hold_code);
		ctx_t r;
		r = c;
		if (r.st.end_pending_tap && !r.st.tap_pressed && !r.st.tap_deferred) begin
			r = release_hold(r, hold_code);
		end
		return r;
	endfunction

	function automatic ctx_t end_session(ctx_t c, logic [31:0] hold_code);
		ctx_t r;
		r = c;
		r.st.idle_armed = 1'b0;
		if (!r.st.session_active && !r.st.hold_pressed && !r.st.tap_deferred) begin
			r = r;
		end else if (r.st.tap_deferred && !r.st.tap_pressed) begin
			r = release_hold(r, hold_code);
		end else if (r.st.tap_pressed) begin
			r.st.end_pending_tap = 1'b1;
			r.st.session_active = 1'b0;
		end else begin
			r = release_hold(r, hold_code);
		end
		return r;
	endfunction

	function automatic ctx_t push_tap(ctx_t c, logic [31:0] code);
		ctx_t r;
		r = release_tap(c);
		r.st.tap_key = code;
		r.st.tap_pressed = 1'b1;
		r = emit(r, code, 1'b1);
		return r;
	endfunction

endpackage

[rtl/encoder_hold_and_tap_sequencer.sv]
// ----------------------------------------------------------------------------
// Encoder hold and tap sequencer
// Turns detent, key and tick requests into hold key and tap key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, operation, tap_key) takes one request:
//   detent press, detent release, other key press or a millisecond tick.
//   Output channel (out_valid/out_ready, key_code, key_down, last_of_run)
//   delivers the key events a request causes, zero to five, in order;
//   last_of_run marks the final event of a request.
//   Configuration (cfg_en, cfg_index, cfg_data) writes the hold keycode,
//   idle window, arm delay and tap length registers.
// Timing:
//   A request is held in the input register, where the state update and its
//   event list are formed; the list is then registered into the event buffer.
//   A request is taken every cycle as long as the event buffer can take its
//   events; a request with k events holds the output until all k are taken,
//   requests without events pass at one per cycle.
// Reset and stall:
//   arst_n clears the session state, loads the default register values and
//   empties both stages. A stalled receiver freezes the event buffer; the
//   input register then holds the next request with events and in_ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module encoder_hold_and_tap_sequencer
	import ehts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] tap_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] key_code,
	output logic        key_down,
	output logic        last_of_run,
	input  logic        cfg_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] hold_key_q;
	logic [15:0] idle_window_q;
	logic [7:0]  arm_delay_q;
	logic [7:0]  tap_length_q;

	state_t      st_q;

	logic        valid_s1;
	op_t         op_s1;
	logic [31:0] key_s1;

	event_t [MaxEv-1:0] ev_s2;
	logic [CntW-1:0]    cnt_s2;
	logic [CntW-1:0]    idx_s2;

	ctx_t        nxt;
	logic        tap_fire;
	logic        arm_fire;
	logic        idle_fire;
	logic        pop;
	logic        pop_last;
	logic        buf_free;
	logic        proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_key_q    <= HoldKeyRst;
			idle_window_q <= IdleWindowRst;
			arm_delay_q   <= ArmDelayRst;
			tap_length_q  <= TapLengthRst;
		end else if (cfg_en) begin
			case (reg_idx_t'(cfg_index))
				REG_HOLD_KEY:    hold_key_q    <= cfg_data;
				REG_IDLE_WINDOW: idle_window_q <= cfg_data[15:0];
				REG_ARM_DELAY:   arm_delay_q   <= cfg_data[7:0];
				REG_TAP_LENGTH:  tap_length_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nxt = '0;
		nxt.st = st_q;
		tap_fire = 1'b0;
		arm_fire = 1'b0;
		idle_fire = 1'b0;
		case (op_s1)
			OP_DETENT_PRESS: begin
				nxt.st.session_active = 1'b1;
				nxt.st.end_pending_tap = 1'b0;
				nxt.st.idle_cnt = idle_window_q;
				nxt.st.idle_armed = 1'b1;
				if (!st_q.hold_pressed) begin
					nxt.st.hold_pressed = 1'b1;
					nxt = emit(nxt, hold_key_q, 1'b1);
					nxt.st.tap_deferred = 1'b1;
					nxt.st.tap_key = key_s1;
					nxt.st.arm_cnt = arm_delay_q;
				end else begin
					nxt.st.tap_deferred = 1'b0;
					nxt.st.tap_self_timed = 1'b0;
					nxt.st.tap_armed = 1'b0;
					nxt = push_tap(nxt, key_s1);
				end
			end
			OP_DETENT_RELEASE: begin
				if (!st_q.tap_deferred && !st_q.tap_self_timed) begin
					nxt = after_tap(release_tap(nxt), hold_key_q);
				end
			end
			OP_OTHER_KEY: begin
				if (st_q.session_active || st_q.hold_pressed) begin
					nxt = end_session(nxt, hold_key_q);
				end
			end
			default: begin
				// count down: tap first, then arm, then idle
				if (st_q.tap_armed) begin
					if (st_q.tap_cnt <= 8'd1) begin
						nxt.st.tap_cnt = 8'd0;
						tap_fire = 1'b1;
					end else begin
						nxt.st.tap_cnt = st_q.tap_cnt - 8'd1;
					end
				end
				if (st_q.tap_deferred) begin
					if (st_q.arm_cnt <= 8'd1) begin
						nxt.st.arm_cnt = 8'd0;
						arm_fire = 1'b1;
					end else begin
						nxt.st.arm_cnt = st_q.arm_cnt - 8'd1;
					end
				end
				if (st_q.idle_armed) begin
					if (st_q.idle_cnt <= 16'd1) begin
						nxt.st.idle_cnt = 16'd0;
						idle_fire = 1'b1;
					end else begin
						nxt.st.idle_cnt = st_q.idle_cnt - 16'd1;
					end
				end
				if (tap_fire) begin
					nxt.st.tap_armed = 1'b0;
					if (nxt.st.tap_self_timed) begin
						nxt = after_tap(release_tap(nxt), hold_key_q);
					end
				end
				if (arm_fire && nxt.st.tap_deferred) begin
					nxt.st.tap_deferred = 1'b0;
					if (nxt.st.hold_pressed && nxt.st.session_active) begin
						nxt = push_tap(nxt, nxt.st.tap_key);
						nxt.st.tap_self_timed = 1'b1;
						nxt.st.tap_cnt = tap_length_q;
						nxt.st.tap_armed = 1'b1;
					end
				end
				if (idle_fire) begin
					nxt.st.idle_armed = 1'b0;
					nxt = end_session(nxt, hold_key_q);
				end
			end
		endcase
	end

	assign out_valid   = (cnt_s2 != '0);
	assign last_of_run = (idx_s2 == cnt_s2 - CntW'(1));
	assign key_code    = ev_s2[idx_s2].code;
	assign key_down    = ev_s2[idx_s2].down;
	assign pop         = out_valid && out_ready;
	assign pop_last    = pop && last_of_run;
	assign buf_free    = !out_valid || pop_last;
	assign proc        = valid_s1 && ((nxt.cnt == '0) || buf_free);
	assign in_ready    = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= op_t'(operation);
			key_s1 <= tap_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (proc) begin
			st_q <= nxt.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			idx_s2 <= '0;
		end else if (proc && (nxt.cnt != '0)) begin
			cnt_s2 <= nxt.cnt;
			idx_s2 <= '0;
		end else if (pop_last) begin
			cnt_s2 <= '0;
			idx_s2 <= '0;
		end else if (pop) begin
			idx_s2 <= idx_s2 + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (nxt.cnt != '0)) begin
			ev_s2 <= nxt.ev;
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_s2 <= CntW'(MaxEv))
	`ASSERT_IMPLY(a_idx_in_run, clk, arst_n, out_valid, idx_s2 < cnt_s2)
	`ASSERT_NEXT(a_stall_holds_idx, clk, arst_n, out_valid && !out_ready, $stable(idx_s2))
	`ASSERT_IMPLY(a_deferred_needs_hold, clk, arst_n, st_q.tap_deferred, st_q.hold_pressed)

endmodule

[sim/key_event_checker.sv]
// ----------------------------------------------------------------------------
// Key event checker
// Watches the request, event and register ports of the hold and tap
// sequencer, predicts the key events of each accepted request and compares
// every delivered event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module key_event_checker
	import ehts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] tap_key,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] key_code,
	input  logic        key_down,
	input  logic        last_of_run,
	input  logic        cfg_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          events_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] code;
		logic        down;
		logic        last;
	} key_event_t;

	logic [31:0] hold_code;
	logic [15:0] idle_ms;
	logic [7:0]  arm_ms;
	logic [7:0]  tap_ms;

	logic        sess_on;
	logic        hold_on;
	logic        tap_on;
	logic        tap_waiting;
	logic        tap_timed;
	logic        lift_pending;
	logic [31:0] tap_code;
	logic [15:0] idle_left;
	logic        idle_run;
	logic [7:0]  arm_left;
	logic [7:0]  tap_left;
	logic        tap_run;

	key_event_t run_events[$];
	key_event_t expected_key_events[$];

	initial begin
		mismatches = 0;
		events_outstanding = 0;
	end

	function automatic void add_event(logic [31:0] code, logic down);
		key_event_t ev;
		if (run_events.size() < MaxEv) begin
			ev.code = code;
			ev.down = down;
			ev.last = 1'b0;
			run_events.push_back(ev);
		end
	endfunction

	function automatic void lift_tap();
		if (tap_on) begin
			tap_on = 1'b0;
			tap_timed = 1'b0;
			add_event(tap_code, 1'b0);
		end
	endfunction

	function automatic void lift_hold();
		sess_on = 1'b0;
		lift_pending = 1'b0;
		tap_waiting = 1'b0;
		if (hold_on) begin
			hold_on = 1'b0;
			add_event(hold_code, 1'b0);
		end
	endfunction

	function automatic void finish_after_tap();
		if (lift_pending && !tap_on && !tap_waiting)
			lift_hold();
	endfunction

	function automatic void close_session();
		idle_run = 1'b0;
		if (sess_on || hold_on || tap_waiting) begin
			if (tap_waiting && !tap_on) begin
				lift_hold();
			end else if (tap_on) begin
				lift_pending = 1'b1;
				sess_on = 1'b0;
			end else begin
				lift_hold();
			end
		end
	endfunction

	function automatic void strike_tap(logic [31:0] code);
		lift_tap();
		tap_code = code;
		tap_on = 1'b1;
		add_event(code, 1'b1);
	endfunction

	function automatic void predict_key_events(op_t op, logic [31:0] key);
		logic       fresh;
		logic       tap_fire;
		logic       arm_fire;
		logic       idle_fire;
		key_event_t ev;
		tap_fire = 1'b0;
		arm_fire = 1'b0;
		idle_fire = 1'b0;
		run_events.delete();
		case (op)
			OP_DETENT_PRESS: begin
				fresh = !hold_on;
				sess_on = 1'b1;
				lift_pending = 1'b0;
				idle_left = idle_ms;
				idle_run = 1'b1;
				if (fresh) begin
					hold_on = 1'b1;
					add_event(hold_code, 1'b1);
					tap_waiting = 1'b1;
					tap_code = key;
					arm_left = arm_ms;
				end else begin
					tap_waiting = 1'b0;
					tap_timed = 1'b0;
					tap_run = 1'b0;
					strike_tap(key);
				end
			end
			OP_DETENT_RELEASE: begin
				if (!tap_waiting && !tap_timed) begin
					lift_tap();
					finish_after_tap();
				end
			end
			OP_OTHER_KEY: begin
				if (sess_on || hold_on)
					close_session();
			end
			default: begin
				if (tap_run) begin
					if (tap_left <= 8'd1) begin
						tap_left = 8'd0;
						tap_fire = 1'b1;
					end else begin
						tap_left = tap_left - 8'd1;
					end
				end
				if (tap_waiting) begin
					if (arm_left <= 8'd1) begin
						arm_left = 8'd0;
						arm_fire = 1'b1;
					end else begin
						arm_left = arm_left - 8'd1;
					end
				end
				if (idle_run) begin
					if (idle_left <= 16'd1) begin
						idle_left = 16'd0;
						idle_fire = 1'b1;
					end else begin
						idle_left = idle_left - 16'd1;
					end
				end
				if (tap_fire) begin
					tap_run = 1'b0;
					if (tap_timed) begin
						lift_tap();
						finish_after_tap();
					end
				end
				if (arm_fire && tap_waiting) begin
					tap_waiting = 1'b0;
					if (hold_on && sess_on) begin
						strike_tap(tap_code);
						tap_timed = 1'b1;
						tap_left = tap_ms;
						tap_run = 1'b1;
					end
				end
				if (idle_fire) begin
					idle_run = 1'b0;
					close_session();
				end
			end
		endcase
		for (int i = 0; i < run_events.size(); i++) begin
			ev = run_events[i];
			ev.last = (i == run_events.size() - 1);
			expected_key_events.push_back(ev);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_event_t want;
		if (!arst_n) begin
			hold_code = HoldKeyRst;
			idle_ms = IdleWindowRst;
			arm_ms = ArmDelayRst;
			tap_ms = TapLengthRst;
			sess_on = 1'b0;
			hold_on = 1'b0;
			tap_on = 1'b0;
			tap_waiting = 1'b0;
			tap_timed = 1'b0;
			lift_pending = 1'b0;
			tap_code = '0;
			idle_left = '0;
			idle_run = 1'b0;
			arm_left = '0;
			tap_left = '0;
			tap_run = 1'b0;
			expected_key_events.delete();
		end else begin
			if (cfg_en) begin
				case (reg_idx_t'(cfg_index))
					REG_HOLD_KEY:    hold_code = cfg_data;
					REG_IDLE_WINDOW: idle_ms = cfg_data[15:0];
					REG_ARM_DELAY:   arm_ms = cfg_data[7:0];
					REG_TAP_LENGTH:  tap_ms = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_key_events(op_t'(operation), tap_key);
			if (out_valid && out_ready) begin
				if (expected_key_events.size() == 0) begin
					$display("%0t: unexpected key event: code %h down %b last %b",
						$realtime, key_code, key_down, last_of_run);
					mismatches++;
				end else begin
					want = expected_key_events.pop_front();
					if (key_code !== want.code || key_down !== want.down ||
							last_of_run !== want.last) begin
						$display("%0t: key event mismatch: expected code %h down %b last %b",
							$realtime, want.code, want.down, want.last);
						$display("%0t:                     actual   code %h down %b last %b",
							$realtime, key_code, key_down, last_of_run);
						mismatches++;
					end
				end
			end
		end
		events_outstanding = expected_key_events.size();
	end

endmodule

[sim/encoder_hold_and_tap_sequencer_test.sv]
// ----------------------------------------------------------------------------
// Hold and tap sequencer testbench
// Drives detent, key and tick requests with random gaps and receiver stalls,
// walks the timing registers through several settings, among them zero and
// all-ones values, and lets the key event checker judge every delivered event.
// ----------------------------------------------------------------------------
module encoder_hold_and_tap_sequencer_test;
	import ehts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit     = 200000;
	localparam int SinkHoldCycles = 150;
	localparam int DrainTail      = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [31:0] tap_key;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] key_code;
	logic        key_down;
	logic        last_of_run;
	logic        cfg_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          mismatches;
	int          events_outstanding;
	int          cycle_count = 0;
	int          hold_off_asks = 0;
	int          hold_offs_served = 0;
	logic        steady = 1'b0;

	encoder_hold_and_tap_sequencer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.tap_key     (tap_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_code    (key_code),
		.key_down    (key_down),
		.last_of_run (last_of_run),
		.cfg_en      (cfg_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	key_event_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.operation          (operation),
		.tap_key            (tap_key),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.key_code           (key_code),
		.key_down           (key_down),
		.last_of_run        (last_of_run),
		.cfg_en             (cfg_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatches         (mismatches),
		.events_outstanding (events_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("encoder_hold_and_tap_sequencer_test failed");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_asks != hold_offs_served) begin
				hold_offs_served++;
				out_ready <= 1'b0;
				repeat (SinkHoldCycles) @(posedge clk);
				out_ready <= 1'b1;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 31);
			end
		end
	end

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic send_request(op_t op, logic [31:0] key);
		if (!steady) begin
			while ($urandom_range(99) < 31) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		operation <= op;
		tap_key <= key;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_requests(int count, int tick_pct);
		int  r;
		op_t op;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < tick_pct) begin
				op = OP_TICK;
			end else begin
				r = $urandom_range(99);
				op = (r < 45) ? OP_DETENT_PRESS : (r < 80) ? OP_DETENT_RELEASE : OP_OTHER_KEY;
			end
			send_request(op, pick_key());
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (events_outstanding != 0) @(negedge clk);
		repeat (DrainTail) @(posedge clk);
	endtask

	task automatic load_settings(logic [31:0] hold, logic [15:0] idle, logic [7:0] arm,
			logic [7:0] tap);
		cfg_en <= 1'b1;
		cfg_index <= REG_HOLD_KEY;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= REG_IDLE_WINDOW;
		cfg_data <= {16'($urandom), idle};
		@(posedge clk);
		cfg_index <= REG_ARM_DELAY;
		cfg_data <= {24'($urandom), arm};
		@(posedge clk);
		cfg_index <= REG_TAP_LENGTH;
		cfg_data <= {24'($urandom), tap};
		@(posedge clk);
		cfg_en <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_TICK;
		tap_key <= '0;
		cfg_en <= 1'b0;
		cfg_index <= REG_HOLD_KEY;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_random_requests(10, 70);
		wait_for_drain();

		load_settings(32'h8000_00E2, 16'd3, 8'd1, 8'd2);
		send_request(OP_DETENT_PRESS, 32'h0000_0000);
		send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_RELEASE, pick_key());
		send_request(OP_TICK, pick_key());
		send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_PRESS, 32'hFFFF_FFFF);
		send_request(OP_DETENT_PRESS, 32'h0000_0000);
		send_request(OP_DETENT_PRESS, 32'hFFFF_FFFF);
		send_request(OP_DETENT_RELEASE, pick_key());
		send_request(OP_DETENT_RELEASE, pick_key());
		send_request(OP_OTHER_KEY, pick_key());
		send_request(OP_OTHER_KEY, pick_key());
		send_request(OP_DETENT_PRESS, 32'h1234_5678);
		send_request(OP_DETENT_PRESS, 32'h0F0F_F0F0);
		send_request(OP_OTHER_KEY, pick_key());
		send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_RELEASE, pick_key());
		send_request(OP_DETENT_PRESS, 32'hA5A5_5A5A);
		send_request(OP_OTHER_KEY, pick_key());
		send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_PRESS, 32'h0000_0001);
		send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_PRESS, 32'h0000_0002);
		repeat (3) send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_RELEASE, pick_key());
		wait_for_drain();

		load_settings(32'h0000_002B, 16'd6, 8'd3, 8'd2);
		send_random_requests(10, 55);
		// stall the receiver while detents keep coming
		hold_off_asks++;
		for (int i = 0; i < 30; i++)
			send_request((i % 3 == 2) ? OP_DETENT_RELEASE : OP_DETENT_PRESS, pick_key());
		send_random_requests(10, 55);
		wait_for_drain();

		load_settings(32'h0000_0001, 16'd1, 8'd1, 8'd1);
		steady = 1'b1;
		send_random_requests(20, 50);
		wait_for_drain();
		steady = 1'b0;

		// zero delays act as one
		load_settings(32'h5A5A_A5A5, 16'd20, 8'd0, 8'd0);
		send_random_requests(15, 55);
		wait_for_drain();

		load_settings(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'h01);
		send_request(OP_DETENT_PRESS, pick_key());
		repeat (256) send_request(OP_TICK, pick_key());
		send_request(OP_DETENT_RELEASE, pick_key());
		send_request(OP_OTHER_KEY, pick_key());
		wait_for_drain();

		load_settings(32'h0001_0000, 16'd12, 8'd4, 8'd7);
		send_random_requests(20, 60);
		wait_for_drain();

		if (mismatches == 0)
			$display("encoder_hold_and_tap_sequencer_test passed");
		else
			$display("encoder_hold_and_tap_sequencer_test failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ehts_pkg.sv
rtl/encoder_hold_and_tap_sequencer.sv
sim/key_event_checker.sv
sim/encoder_hold_and_tap_sequencer_test.sv
